[rtl/core/gregorian_day_difference_top_assert.svh]
// ----------------------------------------------------------------------------
// gregorian_day_difference_top_assert
// Assertion macros for the day difference block.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DAY_DIFFERENCE_TOP_ASSERT_SVH
`define GREGORIAN_DAY_DIFFERENCE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GDD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gdd assertion failed");

// Next-cycle implication, checked outside reset.
`define GDD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gdd assertion failed");

`endif

[rtl/core/gdd_pkg.sv]
// ----------------------------------------------------------------------------
// gdd_pkg
// Types, constants and the month table for the Gregorian day difference block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdd_pkg;

   localparam int YearWidth  = 14;
   localparam int MonthWidth = 4;
   localparam int DayWidth   = 5;
   localparam int CountWidth = 22;
   localparam int SerialWidth = 23;
   localparam int Latency    = 4;

   // floor(x / 100) == (x * Recip100) >> RecipShift for x below 43690
   localparam logic [12:0] Recip100   = 13'd5243;
   localparam int          RecipShift = 19;

   localparam logic [4:0] MonthJan = 5'd1;
   localparam logic [4:0] MonthFeb = 5'd2;
   localparam logic [4:0] MonthDec = 5'd12;

   typedef struct packed {
      logic [YearWidth-1:0]  start_year;
      logic [MonthWidth-1:0] start_month;
      logic [DayWidth-1:0]   start_day;
      logic [YearWidth-1:0]  end_year;
      logic [MonthWidth-1:0] end_month;
      logic [DayWidth-1:0]   end_day;
   } req_type;

   typedef struct packed {
      logic [CountWidth-1:0] day_count;
      logic                  order_error;
   } rsp_type;

   // stage 1: products and table lookups for one date
   typedef struct packed {
      logic [YearWidth-1:0] year;
      logic [22:0]          days365;
      logic [12:0]          quad;
      logic [27:0]          cent_prod;
      logic [25:0]          quad400_prod;
      logic [26:0]          year_prod;
      logic [8:0]           month_base;
      logic                 late_month;
      logic [DayWidth-1:0]  day;
   } lane1_type;

   // stage 2: partial serial number and quotients
   typedef struct packed {
      logic [YearWidth-1:0]   year;
      logic [SerialWidth-1:0] partial;
      logic [7:0]             cent_ceil;
      logic [5:0]             quad400_ceil;
      logic [7:0]             cent_floor;
      logic                   late_month;
   } lane2_type;

   function automatic logic [8:0] days_before_month(input logic [MonthWidth-1:0] month);
      logic [8:0] days;
      case (month)
         4'd0, 4'd1: days = 9'd0;
         4'd2:       days = 9'd31;
         4'd3:       days = 9'd59;
         4'd4:       days = 9'd90;
         4'd5:       days = 9'd120;
         4'd6:       days = 9'd151;
         4'd7:       days = 9'd181;
         4'd8:       days = 9'd212;
         4'd9:       days = 9'd243;
         4'd10:      days = 9'd273;
         4'd11:      days = 9'd304;
         default:    days = 9'd334;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

[rtl/core/gregorian_day_difference_top.sv]
// ----------------------------------------------------------------------------
// gregorian_day_difference_top
// Days between two Gregorian dates, as a four-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_item with start and end dates and raise start. The transfer
//   happens at a rising edge where start is high and busy is low.
//   Each date becomes a serial day number: 365 per year plus leap days
//   (quotient by 4 by a shift, by 100 and 400 by reciprocal multiplies),
//   plus the days before the month and the day field. The result is end
//   minus start (all ones if too large), or zero with order_error set
//   when the end date is earlier. The result appears on rsp_item with
//   rsp_valid high for one cycle, after the four register stages
//   (multiply, quotient and sum, leap correction, compare). One transfer
//   per cycle is taken while busy is low; throughput is one item per clock.
//   Reset: synchronous, active high; clears all stage valids and holds busy
//   high for the cycle after reset. Items in flight are dropped.
//   The receiver cannot stall: every result is presented exactly once.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_day_difference_top
   import gdd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_item,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   logic      busy_ff;
   logic      s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic      accept;

   lane1_type s1_ff [2];
   lane1_type s1_in [2];
   lane2_type s2_ff [2];
   lane2_type s2_in [2];
   logic [SerialWidth-1:0] s3_ff [2];
   logic [SerialWidth-1:0] s3_in [2];
   rsp_type   s4_ff;
   rsp_type   s4_in;

   logic [YearWidth-1:0]  yr    [2];
   logic [MonthWidth-1:0] mon   [2];
   logic [DayWidth-1:0]   dy    [2];
   logic [14:0]           cent_sum [2];
   logic [14:0]           quad_sum [2];
   logic [14:0]           q400_sum [2];
   logic [14:0]           rem100   [2];
   logic                  leap     [2];
   logic [SerialWidth-1:0] diff;

   assign accept = start && !busy_ff;

   // stage 1: multiplies and month table
   always_comb begin
      yr[0]  = req_item.start_year;
      mon[0] = req_item.start_month;
      dy[0]  = req_item.start_day;
      yr[1]  = req_item.end_year;
      mon[1] = req_item.end_month;
      dy[1]  = req_item.end_day;
      for (int i = 0; i < 2; i++) begin
         cent_sum[i] = 15'(yr[i]) + 15'd99;
         quad_sum[i] = 15'(yr[i]) + 15'd3;
         q400_sum[i] = 15'(yr[i]) + 15'd399;
         s1_in[i].year         = yr[i];
         s1_in[i].days365      = 23'(yr[i]) * 23'd365;
         s1_in[i].quad         = quad_sum[i][14:2];
         s1_in[i].cent_prod    = 28'(cent_sum[i]) * 28'(Recip100);
         s1_in[i].quad400_prod = 26'(q400_sum[i][14:2]) * 26'(Recip100);
         s1_in[i].year_prod    = 27'(yr[i]) * 27'(Recip100);
         s1_in[i].month_base   = days_before_month(mon[i]);
         s1_in[i].late_month   = 5'(mon[i]) > MonthFeb;
         s1_in[i].day          = dy[i];
      end
   end

   // stage 2: quotients and partial sum
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s2_in[i].year         = s1_ff[i].year;
         s2_in[i].partial      = s1_ff[i].days365 + 23'(s1_ff[i].quad)
                               + 23'(s1_ff[i].month_base) + 23'(s1_ff[i].day);
         s2_in[i].cent_ceil    = s1_ff[i].cent_prod[RecipShift+7:RecipShift];
         s2_in[i].quad400_ceil = s1_ff[i].quad400_prod[RecipShift+5:RecipShift];
         s2_in[i].cent_floor   = s1_ff[i].year_prod[RecipShift+7:RecipShift];
         s2_in[i].late_month   = s1_ff[i].late_month;
      end
   end

   // stage 3: leap test and serial number
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rem100[i] = 15'(s2_ff[i].year) - 15'(s2_ff[i].cent_floor) * 15'd100;
         leap[i]   = (s2_ff[i].year[1:0] == 2'b00)
                   && ((rem100[i] != 15'd0) || (s2_ff[i].cent_floor[1:0] == 2'b00));
         s3_in[i]  = s2_ff[i].partial - 23'(s2_ff[i].cent_ceil)
                   + 23'(s2_ff[i].quad400_ceil)
                   + 23'(leap[i] && s2_ff[i].late_month);
      end
   end

   // stage 4: compare, subtract, saturate
   always_comb begin
      diff = s3_ff[1] - s3_ff[0];
      if (s3_ff[1] < s3_ff[0]) begin
         s4_in.day_count   = '0;
         s4_in.order_error = 1'b1;
      end else if (diff[SerialWidth-1]) begin
         s4_in.day_count   = '1;
         s4_in.order_error = 1'b0;
      end else begin
         s4_in.day_count   = diff[CountWidth-1:0];
         s4_in.order_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= 1'b0;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = s4_valid_ff;
   assign rsp_item  = s4_ff;

`include "gregorian_day_difference_top_assert.svh"

   `GDD_ASSERT_IMP(a_rsp_follows_transfer, rsp_valid, $past(start && !busy, Latency))
   `GDD_ASSERT_IMP(a_transfer_gives_rsp, start && !busy, ##4 rsp_valid)
   `GDD_ASSERT_NEXT(a_stage_advance, s2_valid_ff, s3_valid_ff)

endmodule

`default_nettype wire
